// File: rtl/block_buffer_tag_directory_assert.svh
`ifndef BLOCK_BUFFER_TAG_DIRECTORY_ASSERT_SVH
`define BLOCK_BUFFER_TAG_DIRECTORY_ASSERT_SVH

// same-cycle implication
`define BBTD_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define BBTD_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/bbtd_pkg.sv
package bbtd_pkg;

  localparam int NUM_BUFFERS = 32;
  localparam int SLOT_W = 5;
  localparam int DEPTH = 1 << SLOT_W;
  localparam int POOL = (NUM_BUFFERS < DEPTH) ? NUM_BUFFERS : DEPTH;
  localparam int DEV_W = 8;
  localparam int BLOCK_W = 32;
  localparam int COUNT_W = 8;

  localparam logic [SLOT_W-1:0] POOL_LAST = SLOT_W'(POOL - 1);
  localparam logic [SLOT_W:0] POOL_SIZE = (SLOT_W + 1)'(POOL);
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef logic [SLOT_W-1:0] slot_t;

  typedef enum logic [1:0] {
    CMD_ACQUIRE = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_PIN     = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NO_FREE   = 2'd1,
    STATUS_UNDERFLOW = 2'd2,
    STATUS_OVERFLOW  = 2'd3
  } status_t;

  typedef struct packed {
    logic               is_tagged;
    logic [DEV_W-1:0]   device;
    logic [BLOCK_W-1:0] blk;
    logic [COUNT_W-1:0] count;
    logic               contents_valid;
  } entry_t;

  typedef struct packed {
    logic  en;
    slot_t addr;
  } rd_req_t;

  typedef struct packed {
    logic   en;
    slot_t  addr;
    entry_t data;
  } wr_req_t;

  typedef struct packed {
    slot_t              buffer_slot;
    logic               hit;
    logic               need_fill;
    logic [COUNT_W-1:0] new_count;
    status_t            status;
  } result_t;

endpackage

// File: rtl/bbtd_ram.sv
module bbtd_ram (
  input  logic             clk,
  input  logic             rst,
  input  bbtd_pkg::rd_req_t rd,
  output bbtd_pkg::entry_t  rd_data,
  input  bbtd_pkg::wr_req_t wr
);
  import bbtd_pkg::*;

  entry_t           mem [DEPTH];
  logic [DEPTH-1:0] live;
  entry_t           rd_q;
  logic             rd_live;

  // written entries are live, the rest read as the reset value
  always_ff @(posedge clk) begin
    if (rst) begin
      live    <= '0;
      rd_live <= 1'b0;
    end else begin
      if (rd.en) begin
        rd_live <= live[rd.addr];
      end
      if (wr.en) begin
        live[wr.addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_q <= mem[rd.addr];
    end
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  assign rd_data = rd_live ? rd_q : '0;

endmodule

// File: rtl/bbtd_ctrl.sv
`include "block_buffer_tag_directory_assert.svh"

module bbtd_ctrl (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        command,
  input  logic [bbtd_pkg::DEV_W-1:0]        device,
  input  logic [bbtd_pkg::BLOCK_W-1:0]      block_number,
  input  bbtd_pkg::slot_t                   slot,
  output bbtd_pkg::rd_req_t                 rd,
  input  bbtd_pkg::entry_t                  rd_data,
  output bbtd_pkg::wr_req_t                 wr,
  output logic                              res_valid,
  input  logic                              res_ready,
  output bbtd_pkg::result_t                 res
);
  import bbtd_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_RMW,
    ST_RESP
  } state_t;

  state_t             state;
  cmd_t               cmd;
  cmd_t               cmd_in;
  logic [DEV_W-1:0]   dev;
  logic [BLOCK_W-1:0] blk;
  slot_t              slot_q;
  slot_t              chk_idx;
  logic               m_found;
  slot_t              m_idx;
  logic [COUNT_W-1:0] m_count;
  logic               m_valid;
  logic               f_found;
  slot_t              f_idx;
  logic               match;
  logic [COUNT_W-1:0] m_up;
  logic [COUNT_W-1:0] rd_up;
  logic [COUNT_W-1:0] rd_down;
  result_t            res_next;

  assign cmd_in   = cmd_t'(command);
  assign in_ready = (state == ST_IDLE);
  assign match    = rd_data.is_tagged && (rd_data.device == dev) && (rd_data.blk == blk);
  assign m_up     = m_count + COUNT_W'(1);
  assign rd_up    = rd_data.count + COUNT_W'(1);
  assign rd_down  = rd_data.count - COUNT_W'(1);

  always_comb begin
    rd       = '0;
    wr       = '0;
    res_next = '0;
    case (state)
      ST_IDLE: begin
        rd.en   = in_valid;
        rd.addr = (cmd_in == CMD_ACQUIRE) ? '0 : slot;
      end
      ST_SCAN: begin
        rd.en   = (chk_idx != POOL_LAST);
        rd.addr = chk_idx + SLOT_W'(1);
      end
      ST_DECIDE: begin
        if (m_found) begin
          if (m_count == COUNT_MAX) begin
            res_next = '{buffer_slot: m_idx, hit: 1'b1, need_fill: 1'b0,
                         new_count: m_count, status: STATUS_OVERFLOW};
          end else begin
            wr.en   = 1'b1;
            wr.addr = m_idx;
            wr.data = '{is_tagged: 1'b1, device: dev, blk: blk, count: m_up,
                        contents_valid: 1'b1};
            res_next = '{buffer_slot: m_idx, hit: 1'b1, need_fill: !m_valid,
                         new_count: m_up, status: STATUS_OK};
          end
        end else if (f_found) begin
          wr.en   = 1'b1;
          wr.addr = f_idx;
          wr.data = '{is_tagged: 1'b1, device: dev, blk: blk, count: COUNT_W'(1),
                      contents_valid: 1'b1};
          res_next = '{buffer_slot: f_idx, hit: 1'b0, need_fill: 1'b1,
                       new_count: COUNT_W'(1), status: STATUS_OK};
        end else begin
          res_next.status = STATUS_NO_FREE;
        end
      end
      ST_RMW: begin
        res_next.buffer_slot = slot_q;
        wr.addr              = slot_q;
        wr.data              = rd_data;
        if (cmd == CMD_RELEASE) begin
          if (rd_data.count == '0) begin
            res_next.status = STATUS_UNDERFLOW;
          end else begin
            wr.en              = 1'b1;
            wr.data.count      = rd_down;
            res_next.new_count = rd_down;
          end
        end else begin
          if (rd_data.count == COUNT_MAX) begin
            res_next.new_count = rd_data.count;
            res_next.status    = STATUS_OVERFLOW;
          end else begin
            wr.en              = 1'b1;
            wr.data.count      = rd_up;
            res_next.new_count = rd_up;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      res_valid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            cmd     <= cmd_in;
            dev     <= device;
            blk     <= block_number;
            slot_q  <= slot;
            chk_idx <= '0;
            m_found <= 1'b0;
            f_found <= 1'b0;
            if (cmd_in == CMD_ACQUIRE) begin
              state <= ST_SCAN;
            end else if (cmd_in == CMD_NONE || {1'b0, slot} >= POOL_SIZE) begin
              res       <= '{buffer_slot: slot, hit: 1'b0, need_fill: 1'b0,
                             new_count: '0, status: STATUS_OK};
              res_valid <= 1'b1;
              state     <= ST_RESP;
            end else begin
              state <= ST_RMW;
            end
          end
        end
        ST_SCAN: begin
          if (!m_found && match) begin
            m_found <= 1'b1;
            m_idx   <= chk_idx;
            m_count <= rd_data.count;
            m_valid <= rd_data.contents_valid;
          end
          if (!f_found && rd_data.count == '0) begin
            f_found <= 1'b1;
            f_idx   <= chk_idx;
          end
          if (chk_idx == POOL_LAST) begin
            state <= ST_DECIDE;
          end else begin
            chk_idx <= chk_idx + SLOT_W'(1);
          end
        end
        ST_DECIDE, ST_RMW: begin
          res       <= res_next;
          res_valid <= 1'b1;
          state     <= ST_RESP;
        end
        ST_RESP: begin
          if (res_ready) begin
            res_valid <= 1'b0;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `BBTD_ASSERT_IMP(a_write_only_update, clk, rst, wr.en, (state == ST_DECIDE || state == ST_RMW), "memory write outside an update state")
  `BBTD_ASSERT_NXT(a_write_then_resp, clk, rst, wr.en, (state == ST_RESP && res_valid), "update did not produce a result")
  `BBTD_ASSERT_IMP(a_resp_valid, clk, rst, (state == ST_RESP), res_valid, "result state without a valid result")
  `BBTD_ASSERT_IMP(a_hit_status, clk, rst, (res_valid && res.hit), (res.status == STATUS_OK || res.status == STATUS_OVERFLOW), "hit with a bad status")
  `BBTD_ASSERT_IMP(a_scan_bound, clk, rst, (state == ST_SCAN), (chk_idx <= POOL_LAST), "scan ran past the pool")

endmodule

// File: rtl/block_buffer_tag_directory.sv
// Tag directory for a pool of disk block buffers. Each transaction carries a command: acquire
// looks up (device, block_number) and grants the matching slot, or else retags the lowest slot
// whose reference count is zero; release and pin step the count of the addressed slot. One
// result comes back per transaction with the slot, hit, need_fill, the new count and a status
// (ok, no free buffer, underflow, overflow). The slot entries live in one tag memory with a
// single read port, so an acquire reads every slot of the pool in turn before it decides;
// release and pin read only the addressed slot. Transactions are handled one at a time. A
// finished result sits in an output register, and the next transaction is accepted while it
// waits there.
module block_buffer_tag_directory (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   command,
  input  logic [bbtd_pkg::DEV_W-1:0]   device,
  input  logic [bbtd_pkg::BLOCK_W-1:0] block_number,
  input  logic [bbtd_pkg::SLOT_W-1:0]  slot,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [bbtd_pkg::SLOT_W-1:0]  buffer_slot,
  output logic                         hit,
  output logic                         need_fill,
  output logic [bbtd_pkg::COUNT_W-1:0] new_count,
  output logic [1:0]                   status
);
  import bbtd_pkg::*;

  rd_req_t rd;
  wr_req_t wr;
  entry_t  rd_data;
  logic    res_valid;
  logic    res_ready;
  result_t res;
  result_t out_q;

  bbtd_ram u_ram (
    .clk     (clk),
    .rst     (rst),
    .rd      (rd),
    .rd_data (rd_data),
    .wr      (wr)
  );

  bbtd_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .command      (command),
    .device       (device),
    .block_number (block_number),
    .slot         (slot),
    .rd           (rd),
    .rd_data      (rd_data),
    .wr           (wr),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res          (res)
  );

  // output register
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign buffer_slot = out_q.buffer_slot;
  assign hit         = out_q.hit;
  assign need_fill   = out_q.need_fill;
  assign new_count   = out_q.new_count;
  assign status      = out_q.status;

endmodule
